// ===== sv/alid_pkg.sv =====
// ----------------------------------------------------------------------------
// alid_pkg: shared types and constants for the array list block
// Widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package alid_pkg;

	localparam int LIST_DEPTH = 64;
	localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	localparam int FUNC_W = 2;
	localparam int CODE_W = 32;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int OCNT_W = 7;
	localparam int HIT_W  = 7;

	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	localparam int S_TDATA_W = ((CODE_W + POS_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((OCNT_W + CODE_W + HIT_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 2'd0,
		FN_DELETE = 2'd1,
		FN_INSERT = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_POS   = 2'd3
	} status_t;

	typedef struct packed {
		logic take_prev;
		logic take_next;
		logic take_code;
	} cell_ctrl_t;

endpackage

// ===== sv/array_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_delete_top: ordered list of codes in a row of cells
// Append, delete last occurrence, insert at position and read at position.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_*      in   code[31:0], position[38:32]              func
//   m_*      out  entry_count[6:0], read_code[38:7],       status
//                 hit_position[45:39]
//
// On accept every cell's compare is registered; the execute state then
// resolves the last match and position, shifts the row and loads the
// result register.
// Reset clears the count and control; cell contents need no clearing.
// A pending result stalls only the execute state; s_tready stays low from
// each transfer until that operation commits.
// ----------------------------------------------------------------------------
module array_list_insert_delete_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [alid_pkg::S_TDATA_W-1:0] s_tdata,  // code, position
	input  logic [alid_pkg::FUNC_W-1:0]    s_tuser,  // func
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [alid_pkg::M_TDATA_W-1:0] m_tdata,  // entry_count, read_code, hit_position
	output logic [alid_pkg::STAT_W-1:0]    m_tuser   // status
);
	import alid_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  cnt_q;
	func_t             func_s1;
	logic [CODE_W-1:0] code_s1;
	logic [POS_W-1:0]  pos_s1;
	logic [LIST_DEPTH-1:0] match_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [OCNT_W-1:0] ocnt_q;
	logic [CODE_W-1:0] rcode_q;
	logic [HIT_W-1:0]  hit_q;

	logic [CODE_W-1:0] in_code;
	logic [POS_W-1:0]  in_pos;
	logic              accept;
	logic              commit;

	logic [CODE_W-1:0] entry [LIST_DEPTH];
	cell_ctrl_t        ctrl  [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match;
	logic [LIST_DEPTH-1:0] valid;
	logic [LIST_DEPTH-1:0] above;
	logic [LIST_DEPTH-1:0] last;
	logic [LIST_DEPTH-1:0] sel_pos;
	logic [LIST_DEPTH-1:0] ge_pos;
	logic [LIST_DEPTH-1:0] sel_cnt;

	logic [CMP_W-1:0]  cnt_ext;
	logic [CMP_W-1:0]  pos_ext;
	logic              full;
	logic              found;
	logic              ins_ok;
	logic              rd_ok;
	logic [IDX_W-1:0]  at_idx;
	logic [CODE_W-1:0] rd_word;

	logic              do_append;
	logic              do_delete;
	logic              do_insert;
	status_t           status_d;
	logic [CODE_W-1:0] rcode_d;
	logic [HIT_W-1:0]  hit_d;
	logic [CNT_W-1:0]  cnt_d;

	assign in_code = s_tdata[CODE_W-1:0];
	assign in_pos  = s_tdata[CODE_W+POS_W-1:CODE_W];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign commit   = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	assign cnt_ext = CMP_W'(cnt_q);
	assign pos_ext = CMP_W'(pos_s1);

	genvar gi;
	generate
		for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
			assign valid[gi]   = CMP_W'(gi) < cnt_ext;
			assign above[gi]   = |(match_s1 >> (gi + 1));
			assign last[gi]    = match_s1[gi] && !above[gi];
			assign sel_pos[gi] = (CMP_W'(gi) + CMP_W'(1)) == pos_ext;
			assign ge_pos[gi]  = CMP_W'(gi) >= pos_ext;
			assign sel_cnt[gi] = CMP_W'(gi) == cnt_ext;

			assign ctrl[gi].take_code = (do_append && sel_cnt[gi])
				|| (do_insert && sel_pos[gi]);
			assign ctrl[gi].take_prev = do_insert && ge_pos[gi];
			assign ctrl[gi].take_next = do_delete && !above[gi];

			alid_cell u_cell (
				.clk        (clk),
				.valid      (valid[gi]),
				.cmp_code   (in_code),
				.load_code  (code_s1),
				.prev_entry ((gi == 0) ? '0 : entry[(gi == 0) ? 0 : gi - 1]),
				.next_entry ((gi == LIST_DEPTH - 1) ? '0
					: entry[(gi == LIST_DEPTH - 1) ? gi : gi + 1]),
				.ctrl       (ctrl[gi]),
				.entry      (entry[gi]),
				.match      (match[gi])
			);
		end
	endgenerate

	assign full   = cnt_ext == CMP_W'(LIST_DEPTH);
	assign found  = |match_s1;
	assign ins_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
	assign rd_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

	always_comb begin
		at_idx  = '0;
		rd_word = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (last[i]) at_idx |= IDX_W'(i);
			if (sel_pos[i]) rd_word |= entry[i];
		end
	end

	always_comb begin
		do_append = 1'b0;
		do_delete = 1'b0;
		do_insert = 1'b0;
		status_d  = ST_OK;
		rcode_d   = '0;
		hit_d     = '0;
		cnt_d     = cnt_q;
		unique case (func_s1)
			FN_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					do_append = commit;
					cnt_d     = cnt_q + CNT_W'(1);
					hit_d     = HIT_W'(cnt_d);
				end
			end
			FN_DELETE: begin
				if (!found) begin
					status_d = ST_NOT_FOUND;
				end else begin
					do_delete = commit;
					cnt_d     = cnt_q - CNT_W'(1);
					hit_d     = HIT_W'(at_idx) + HIT_W'(1);
				end
			end
			FN_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (!ins_ok) begin
					status_d = ST_BAD_POS;
				end else begin
					do_insert = commit;
					cnt_d     = cnt_q + CNT_W'(1);
					hit_d     = HIT_W'(pos_s1);
				end
			end
			FN_READ: begin
				if (!rd_ok) begin
					status_d = ST_BAD_POS;
				end else begin
					rcode_d = rd_word;
					hit_d   = HIT_W'(pos_s1);
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_EXEC;
				S_EXEC: if (commit) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				cnt_q       <= cnt_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func_t'(s_tuser);
			code_s1  <= in_code;
			pos_s1   <= in_pos;
			match_s1 <= match;
		end
		if (commit) begin
			status_q <= status_d;
			ocnt_q   <= OCNT_W'(cnt_d);
			rcode_q  <= rcode_d;
			hit_q    <= hit_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({hit_q, rcode_q, ocnt_q});

	// hold the count within the store
	assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= CMP_W'(LIST_DEPTH))
		else $error("list count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> (hit_q == '0) && (rcode_q == '0))
		else $error("error result carries a position or code");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second transfer taken during execute cycle");

	assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cnt_q))
		else $error("count moved without a commit");

	assert property (@(posedge clk) disable iff (!arst_n)
		commit && (status_d != ST_OK) |=> cnt_q == $past(cnt_q))
		else $error("failed operation changed the count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && (func_s1 == FN_DELETE) |-> $onehot0(last))
		else $error("more than one last match");

endmodule

// ===== sv/alid_cell.sv =====
// ----------------------------------------------------------------------------
// alid_cell: one list slot
// Holds one code, compares it with the incoming code and loads from its
// lower neighbour, its upper neighbour or the new code.
// ----------------------------------------------------------------------------
module alid_cell (
	input  logic                     clk,
	input  logic                     valid,
	input  logic [alid_pkg::CODE_W-1:0] cmp_code,
	input  logic [alid_pkg::CODE_W-1:0] load_code,
	input  logic [alid_pkg::CODE_W-1:0] prev_entry,
	input  logic [alid_pkg::CODE_W-1:0] next_entry,
	input  alid_pkg::cell_ctrl_t     ctrl,
	output logic [alid_pkg::CODE_W-1:0] entry,
	output logic                     match
);
	import alid_pkg::*;

	logic [CODE_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.take_code) begin
			entry_q <= load_code;
		end else if (ctrl.take_prev) begin
			entry_q <= prev_entry;
		end else if (ctrl.take_next) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign match = valid && (entry_q == cmp_code);

endmodule

// ===== sim/alid_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alid_list_checker: list operation predictor and result checker
// Watches both stream channels of the array list block. Every accepted
// operation is applied to a private copy of the list, and the answer it
// should give is queued. Every accepted result is compared field by field
// with the oldest queued answer.
// ----------------------------------------------------------------------------
module alid_list_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [alid_pkg::S_TDATA_W-1:0] s_tdata,  // code, position
	input  logic [alid_pkg::FUNC_W-1:0]    s_tuser,  // func
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [alid_pkg::M_TDATA_W-1:0] m_tdata,  // entry_count, read_code, hit_position
	input  logic [alid_pkg::STAT_W-1:0]    m_tuser,  // status
	output int                             outstanding,
	output int                             list_size,
	output int                             mismatches
);
	import alid_pkg::*;

	typedef struct packed {
		status_t           status;
		logic [OCNT_W-1:0] entry_count;
		logic [CODE_W-1:0] read_code;
		logic [HIT_W-1:0]  hit_position;
	} list_answer_t;

	logic [CODE_W-1:0] held_codes [LIST_DEPTH];
	int                held = 0;
	int                errors = 0;
	list_answer_t      pending_answers [$];

	function automatic list_answer_t apply_list_op(func_t fn, logic [CODE_W-1:0] code,
			logic [POS_W-1:0] pos);
		list_answer_t a;
		int           at;
		int           p;
		a.status       = ST_OK;
		a.read_code    = '0;
		a.hit_position = '0;
		p              = int'(pos);
		case (fn)
			FN_APPEND: begin
				if (held >= LIST_DEPTH) begin
					a.status = ST_FULL;
				end else begin
					held_codes[held] = code;
					held++;
					a.hit_position = HIT_W'(held);
				end
			end
			FN_DELETE: begin
				at = -1;
				for (int i = 0; i < held; i++)
					if (held_codes[i] == code)
						at = i;
				if (at < 0) begin
					a.status = ST_NOT_FOUND;
				end else begin
					for (int i = at; i + 1 < held; i++)
						held_codes[i] = held_codes[i + 1];
					held--;
					a.hit_position = HIT_W'(at + 1);
				end
			end
			FN_INSERT: begin
				if (held >= LIST_DEPTH) begin
					a.status = ST_FULL;
				end else if (p < 1 || p > held + 1) begin
					a.status = ST_BAD_POS;
				end else begin
					for (int i = held; i > p - 1; i--)
						held_codes[i] = held_codes[i - 1];
					held_codes[p - 1] = code;
					held++;
					a.hit_position = HIT_W'(p);
				end
			end
			default: begin
				if (p < 1 || p > held) begin
					a.status = ST_BAD_POS;
				end else begin
					a.read_code    = held_codes[p - 1];
					a.hit_position = HIT_W'(p);
				end
			end
		endcase
		a.entry_count = OCNT_W'(held);
		return a;
	endfunction

	task automatic check_field(string field, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		list_answer_t want;
		list_answer_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.status       = status_t'(m_tuser);
				got.entry_count  = m_tdata[OCNT_W-1:0];
				got.read_code    = m_tdata[OCNT_W +: CODE_W];
				got.hit_position = m_tdata[OCNT_W + CODE_W +: HIT_W];
				if (pending_answers.size() == 0) begin
					$display({"%0t: unexpected result, expected none, actual status %0d",
						" count %0d code 0x%0h position %0d"},
						$time, got.status, got.entry_count, got.read_code, got.hit_position);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					check_field("status", CODE_W'(want.status), CODE_W'(got.status));
					check_field("entry_count", CODE_W'(want.entry_count),
						CODE_W'(got.entry_count));
					check_field("read_code", want.read_code, got.read_code);
					check_field("hit_position", CODE_W'(want.hit_position),
						CODE_W'(got.hit_position));
				end
			end
			if (s_tvalid && s_tready)
				pending_answers.push_back(apply_list_op(func_t'(s_tuser), s_tdata[CODE_W-1:0],
					s_tdata[CODE_W +: POS_W]));
		end
		outstanding <= pending_answers.size();
		list_size   <= held;
		mismatches  <= errors;
	end

endmodule

// ===== sim/tb_array_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_top: stimulus and verdict for the array list
// Directed operations on an empty and a short list, then bursts of random
// operations that fill, drain or mix the list, with random gaps on the
// operation side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_top;
	import alid_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 750;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 16;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]    m_tuser;

	int                outstanding;
	int                list_size;
	int                mismatches;
	int                idle_cycles = 0;
	int                rx_hold = 0;
	bit                stim_done = 1'b0;
	bit                tx_quiet = 1'b0;
	bit                rx_quiet = 1'b0;
	logic [CODE_W-1:0] code_pool [16];

	array_list_insert_delete_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	alid_list_checker list_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.outstanding (outstanding),
		.list_size   (list_size),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 3) != 0)
			return code_pool[$urandom_range(0, 15)];
		return $urandom();
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(0, 4) != 0)
			return POS_W'($urandom_range(0, list_size + 1));
		return POS_W'($urandom_range(0, 127));
	endfunction

	function automatic func_t pick_func(burst_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL:
				return (r < 45) ? FN_APPEND : (r < 85) ? FN_INSERT : (r < 93) ? FN_READ : FN_DELETE;
			MODE_DRAIN:
				return (r < 65) ? FN_DELETE : (r < 80) ? FN_READ : (r < 90) ? FN_INSERT : FN_APPEND;
			default:
				return func_t'(r % 4);
		endcase
	endfunction

	task automatic send_op(func_t fn, logic [CODE_W-1:0] code, logic [POS_W-1:0] pos);
		int gap;
		gap = tx_quiet ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= S_TDATA_W'({pos, code});
		do @(posedge clk); while (!s_tready);
	endtask

	// result side: random stalls, some bursts held ready throughout
	initial begin
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_quiet && $urandom_range(0, 3) == 0)
					rx_hold = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && (!stim_done || outstanding != 0)) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_array_list_insert_delete_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int          done_items;
		int          burst;
		burst_mode_t mode;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		arst_n   = 1'b0;
		foreach (code_pool[i])
			code_pool[i] = $urandom();
		code_pool[0] = '0;
		code_pool[1] = '1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_op(FN_READ, 32'h0, 7'd1);
		send_op(FN_READ, 32'h0, 7'd0);
		send_op(FN_DELETE, 32'h0, 7'd0);
		send_op(FN_INSERT, 32'h1111_1111, 7'd2);
		send_op(FN_INSERT, 32'h2222_2222, 7'd0);
		// build a short list with a repeated code
		send_op(FN_INSERT, 32'hFFFF_FFFF, 7'd1);
		send_op(FN_APPEND, 32'h0, 7'd0);
		send_op(FN_APPEND, 32'hA5A5_5A5A, 7'd0);
		send_op(FN_APPEND, 32'h0, 7'd0);
		send_op(FN_INSERT, 32'h8000_0001, 7'd5);
		send_op(FN_INSERT, 32'h1234_5678, 7'd2);
		send_op(FN_DELETE, 32'h0, 7'd0);
		send_op(FN_READ, 32'h0, 7'd1);
		send_op(FN_READ, 32'h0, 7'd5);
		send_op(FN_READ, 32'h0, 7'd6);
		send_op(FN_READ, 32'h0, 7'd127);
		send_op(FN_INSERT, 32'h5A5A_A5A5, 7'd127);
		send_op(FN_DELETE, 32'hDEAD_BEEF, 7'd0);
		send_op(FN_DELETE, 32'hFFFF_FFFF, 7'd127);
		send_op(FN_READ, 32'hFFFF_FFFF, 7'd1);
		send_op(FN_APPEND, 32'h7FFF_FFFF, 7'd127);

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			mode     = burst_mode_t'($urandom_range(0, 2));
			burst    = (mode == MODE_FILL) ? $urandom_range(70, 120) : $urandom_range(30, 90);
			if (burst > RANDOM_ITEMS - done_items)
				burst = RANDOM_ITEMS - done_items;
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			repeat (burst) begin
				send_op(pick_func(mode), pick_code(), pick_pos());
				done_items++;
			end
		end
		s_tvalid  <= 1'b0;
		stim_done = 1'b1;
		rx_quiet  = 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_array_list_insert_delete_top: PASS");
		else
			$display("tb_array_list_insert_delete_top: FAIL");
		$finish;
	end

endmodule
